// ===== sv/bcmp_pkg.sv =====
// ---------------------------------------------------------------------------
// Binomial coefficient package
// Shared constants for the modulo-prime binomial coefficient unit.
// ---------------------------------------------------------------------------
package bcmp_pkg;

   localparam int unsigned VAL_W      = 30;
   localparam logic [VAL_W-1:0] PRIME = 30'd1000000007;
   localparam logic [VAL_W-1:0] FERMAT_EXP = PRIME - 30'd2;
   localparam int unsigned EXP_BITS   = 30;
   localparam int unsigned BARRETT_SHIFT = 60;

   // Barrett reciprocal floor(2^60 / p), a 31-bit value.
   localparam logic [63:0] BARRETT_WIDE = (64'd1 << BARRETT_SHIFT) / 64'd1000000007;
   localparam logic [30:0] BARRETT_M    = BARRETT_WIDE[30:0];

   // Pipeline depth of one modular multiplier.
   localparam int unsigned MUL_LAT = 4;

endpackage

// ===== sv/bcmp_mulmod.sv =====
// ---------------------------------------------------------------------------
// Modular multiplier
// Four-stage pipelined a*b mod p with Barrett reduction.
// ---------------------------------------------------------------------------
module bcmp_mulmod import bcmp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_vld,
   input  logic [VAL_W-1:0] op_a,
   input  logic [VAL_W-1:0] op_b,
   output logic             out_vld,
   output logic [VAL_W-1:0] result
);

   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic [59:0] prod_ff;
   logic [59:0] prod2_ff;
   logic [61:0] q2_ff;
   logic [31:0] rem_ff;
   logic [VAL_W-1:0] res_ff;

   logic [30:0] q3;
   logic [60:0] qp;
   logic [32:0] d1, d2;

   assign q3 = q2_ff[61:31];
   assign qp = q3 * PRIME;
   assign d1 = {1'b0, rem_ff} - 33'(PRIME);
   assign d2 = {1'b0, rem_ff} - (33'(PRIME) << 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_vld;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= op_a * op_b;
         q2_ff    <= prod_ff[59:29] * BARRETT_M;
         prod2_ff <= prod_ff;
         // The remainder is below 3p, so the low 32 bits carry it exactly.
         rem_ff   <= prod2_ff[31:0] - qp[31:0];
         if (!d2[32]) begin
            res_ff <= d2[VAL_W-1:0];
         end else if (!d1[32]) begin
            res_ff <= d1[VAL_W-1:0];
         end else begin
            res_ff <= rem_ff[VAL_W-1:0];
         end
      end
   end

   assign out_vld = v4_ff;
   assign result  = res_ff;

endmodule

// ===== sv/binomial_coefficient_mod_prime_unit.sv =====
// ---------------------------------------------------------------------------
// Binomial coefficient modulo 1000000007
// Table-based n choose r with a pipelined pair of modular multipliers.
// ---------------------------------------------------------------------------
// Usage: a query word carries req_top_count (n) and req_choose_count (r) on a
// valid/ready channel; the answer word rsp_coefficient leaves on the rsp_
// channel, zero when r exceeds n or n is beyond the table.
// After reset the block builds its factorial table (one multiply per entry),
// raises the last factorial to the power p-2 by square-and-multiply (30
// steps), then walks the inverse factorials down the table. Each step issues
// a multiply and waits for its result before the next step starts;
// req_ready stays low until the fill is done.
// Afterwards one query is taken per cycle while the receiver takes answers.
// A query is read from the tables at the edge that accepts it, then passes
// through both chained multipliers and the output register before its word
// appears on rsp_valid.
// When the receiver holds rsp_ready low with a word waiting, the whole
// pipeline freezes and req_ready drops in the same cycle; nothing is lost.
// ---------------------------------------------------------------------------
module binomial_coefficient_mod_prime_unit import bcmp_pkg::*; #(
   parameter int TABLE_SIZE = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [5:0]       req_top_count,
   input  logic [5:0]       req_choose_count,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [VAL_W-1:0] rsp_coefficient
);

   localparam int AW   = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int IW   = ((AW > 6) ? AW : 6) + 1;
   localparam int BITW = $clog2(EXP_BITS);

   typedef enum logic [2:0] {
      S_FISSUE, S_FWAIT, S_PISSUE, S_PWAIT, S_IWRITE, S_IISSUE, S_IWAIT, S_DONE
   } seq_state_type;

   seq_state_type    state_ff;
   logic             done_ff;
   logic [AW-1:0]    k_ff;
   logic [BITW-1:0]  bit_ff;
   logic [VAL_W-1:0] acc_ff;
   logic [VAL_W-1:0] sq_ff;

   logic [VAL_W-1:0] fact_mem [TABLE_SIZE];
   logic [VAL_W-1:0] inv_mem  [TABLE_SIZE];

   logic             en;
   logic             q1_vld_ff;
   logic             q1_zero_ff;
   logic [VAL_W-1:0] fact_rd_ff, inv_nr_rd_ff, inv_r_rd_ff;
   logic [VAL_W-1:0] invr_dly_ff [MUL_LAT];
   logic             zero_dly_ff [2*MUL_LAT];
   logic             rsp_valid_ff;
   logic [VAL_W-1:0] rsp_coef_ff;

   logic [IW-1:0]    n_ext, r_ext, nr_ext;
   logic             q_zero;

   logic             a_vld_in, a_vld_out, b_vld_in, b_vld_out;
   logic [VAL_W-1:0] a_op_a, a_op_b, a_res, b_op_a, b_op_b, b_res;

   logic             fact_we, inv_we;
   logic [AW-1:0]    fact_waddr, inv_waddr;
   logic [VAL_W-1:0] fact_wdata, inv_wdata;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en && done_ff;

   assign n_ext  = IW'(req_top_count);
   assign r_ext  = IW'(req_choose_count);
   assign nr_ext = n_ext - r_ext;
   assign q_zero = (r_ext > n_ext) || (n_ext >= IW'(TABLE_SIZE));

   // Multiplier A serves the fill sequencer until the tables are done, then
   // the first product of each query; B squares during exponentiation and forms the second product afterwards.
   always_comb begin
      if (done_ff) begin
         a_vld_in = q1_vld_ff;
         a_op_a   = fact_rd_ff;
         a_op_b   = inv_nr_rd_ff;
         b_vld_in = a_vld_out;
         b_op_a   = a_res;
         b_op_b   = invr_dly_ff[MUL_LAT-1];
      end else begin
         a_vld_in = (state_ff == S_FISSUE) || (state_ff == S_PISSUE) ||
                    (state_ff == S_IISSUE);
         a_op_a   = acc_ff;
         a_op_b   = (state_ff == S_PISSUE) ? sq_ff : VAL_W'(k_ff);
         b_vld_in = (state_ff == S_PISSUE);
         b_op_a   = sq_ff;
         b_op_b   = sq_ff;
      end
   end

   bcmp_mulmod u_mul_a (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (a_vld_in),
      .op_a    (a_op_a),
      .op_b    (a_op_b),
      .out_vld (a_vld_out),
      .result  (a_res)
   );

   bcmp_mulmod u_mul_b (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (b_vld_in),
      .op_a    (b_op_a),
      .op_b    (b_op_b),
      .out_vld (b_vld_out),
      .result  (b_res)
   );

   // Table write ports, driven by the fill sequencer only.
   always_comb begin
      fact_we    = ((state_ff == S_FWAIT) && a_vld_out) || (state_ff == S_IWRITE);
      fact_waddr = (state_ff == S_IWRITE) ? '0 : k_ff;
      fact_wdata = (state_ff == S_IWRITE) ? VAL_W'(1) : a_res;
      inv_we     = ((state_ff == S_IWAIT) && a_vld_out) || (state_ff == S_IWRITE);
      inv_waddr  = (state_ff == S_IWRITE) ? AW'(TABLE_SIZE - 1) : k_ff - AW'(1);
      inv_wdata  = (state_ff == S_IWRITE) ? acc_ff : a_res;
   end

   always_ff @(posedge clock) begin
      if (fact_we) begin
         fact_mem[fact_waddr] <= fact_wdata;
      end
      if (inv_we) begin
         inv_mem[inv_waddr] <= inv_wdata;
      end
      if (en) begin
         fact_rd_ff   <= fact_mem[n_ext[AW-1:0]];
         inv_nr_rd_ff <= inv_mem[nr_ext[AW-1:0]];
         inv_r_rd_ff  <= inv_mem[r_ext[AW-1:0]];
      end
   end

   // Fill sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_FISSUE;
         done_ff  <= 1'b0;
         k_ff     <= AW'(1);
         bit_ff   <= '0;
         acc_ff   <= VAL_W'(1);
         sq_ff    <= '0;
      end else begin
         unique case (state_ff)
            S_FISSUE: state_ff <= S_FWAIT;
            S_FWAIT: begin
               if (a_vld_out) begin
                  if (k_ff == AW'(TABLE_SIZE - 1)) begin
                     sq_ff    <= a_res;
                     acc_ff   <= VAL_W'(1);
                     bit_ff   <= '0;
                     state_ff <= S_PISSUE;
                  end else begin
                     acc_ff   <= a_res;
                     k_ff     <= k_ff + AW'(1);
                     state_ff <= S_FISSUE;
                  end
               end
            end
            S_PISSUE: state_ff <= S_PWAIT;
            S_PWAIT: begin
               if (a_vld_out) begin
                  if (FERMAT_EXP[bit_ff]) begin
                     acc_ff <= a_res;
                  end
                  sq_ff <= b_res;
                  if (bit_ff == BITW'(EXP_BITS - 1)) begin
                     state_ff <= S_IWRITE;
                  end else begin
                     bit_ff   <= bit_ff + BITW'(1);
                     state_ff <= S_PISSUE;
                  end
               end
            end
            S_IWRITE: begin
               k_ff     <= AW'(TABLE_SIZE - 1);
               state_ff <= S_IISSUE;
            end
            S_IISSUE: state_ff <= S_IWAIT;
            S_IWAIT: begin
               if (a_vld_out) begin
                  acc_ff <= a_res;
                  if (k_ff == AW'(1)) begin
                     done_ff  <= 1'b1;
                     state_ff <= S_DONE;
                  end else begin
                     k_ff     <= k_ff - AW'(1);
                     state_ff <= S_IISSUE;
                  end
               end
            end
            S_DONE: state_ff <= S_DONE;
            default: state_ff <= S_DONE;
         endcase
      end
   end

   // Query pipeline: side data follows the words through both multipliers.
   always_ff @(posedge clock) begin
      if (reset) begin
         q1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         q1_vld_ff    <= req_valid && req_ready;
         rsp_valid_ff <= b_vld_out && done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q1_zero_ff     <= q_zero;
         invr_dly_ff[0] <= inv_r_rd_ff;
         zero_dly_ff[0] <= q1_zero_ff;
         for (int i = 1; i < MUL_LAT; i++) begin
            invr_dly_ff[i] <= invr_dly_ff[i-1];
         end
         for (int i = 1; i < 2*MUL_LAT; i++) begin
            zero_dly_ff[i] <= zero_dly_ff[i-1];
         end
         rsp_coef_ff <= zero_dly_ff[2*MUL_LAT-1] ? '0 : b_res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coefficient = rsp_coef_ff;

   a_no_query_before_fill: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> done_ff)
      else $error("query accepted before tables were filled");

   a_no_rsp_before_fill: assert property (@(posedge clock) disable iff (reset)
      !done_ff |-> !rsp_valid_ff)
      else $error("result produced during table fill");

   a_query_mul_needs_fill: assert property (@(posedge clock) disable iff (reset)
      q1_vld_ff |-> done_ff)
      else $error("query in multiplier during fill");

   a_result_registered: assert property (@(posedge clock) disable iff (reset)
      (en && done_ff && b_vld_out) |=> rsp_valid_ff)
      else $error("finished product not presented");

endmodule

// ===== tb/sv/bcmp_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Binomial coefficient checker
// Watches the query and answer channels, predicts n choose r mod p from
// its own factorial tables and compares every answer word in order.
// ---------------------------------------------------------------------------
module bcmp_checker import bcmp_pkg::*; #(
   parameter int TABLE_SIZE = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic [5:0]       req_top_count,
   input  logic [5:0]       req_choose_count,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic [VAL_W-1:0] rsp_coefficient,
   output int               fail_count,
   output int               pending_count,
   output int               answer_count
);

   logic [VAL_W-1:0] fact_tab [TABLE_SIZE];
   logic [VAL_W-1:0] inv_fact_tab [TABLE_SIZE];
   logic [VAL_W-1:0] coeff_queue [$];

   function automatic logic [VAL_W-1:0] mod_mul(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
      logic [63:0] prod;
      prod = 64'(a) * 64'(b);
      return VAL_W'(prod % 64'(PRIME));
   endfunction

   function automatic logic [VAL_W-1:0] mod_pow(logic [VAL_W-1:0] base, logic [VAL_W-1:0] ex);
      logic [VAL_W-1:0] acc;
      logic [VAL_W-1:0] sq;
      acc = VAL_W'(1);
      sq = base;
      for (int i = 0; i < VAL_W; i++) begin
         if (ex[i]) acc = mod_mul(acc, sq);
         sq = mod_mul(sq, sq);
      end
      return acc;
   endfunction

   function automatic logic [VAL_W-1:0] binom_mod(logic [5:0] n, logic [5:0] r);
      if (r > n || n >= TABLE_SIZE) return '0;
      return mod_mul(mod_mul(fact_tab[n], inv_fact_tab[n - r]), inv_fact_tab[r]);
   endfunction

   task automatic report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   initial begin
      fact_tab[0] = VAL_W'(1);
      inv_fact_tab[0] = VAL_W'(1);
      for (int k = 1; k < TABLE_SIZE; k++) begin
         fact_tab[k] = mod_mul(fact_tab[k-1], VAL_W'(k));
         inv_fact_tab[k] = mod_pow(fact_tab[k], FERMAT_EXP);
      end
      fail_count = 0;
      answer_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            answer_count++;
            if (coeff_queue.size() == 0) begin
               report_mismatch("unexpected word", rsp_coefficient, '0);
            end else begin
               logic [VAL_W-1:0] want;
               want = coeff_queue.pop_front();
               if (rsp_coefficient !== want) report_mismatch("coefficient", rsp_coefficient, want);
            end
         end
         if (req_valid && req_ready)
            coeff_queue.push_back(binom_mod(req_top_count, req_choose_count));
      end
      pending_count = coeff_queue.size();
   end

endmodule

// ===== tb/sv/tb_binomial_coefficient_mod_prime_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Binomial coefficient unit testbench
// Drives directed and random n, r queries with random gaps and stalls,
// including a long answer stall and a full drain, and reports the verdict.
// ---------------------------------------------------------------------------
module tb_binomial_coefficient_mod_prime_unit;
   import bcmp_pkg::*;

   localparam int RANDOM_ITEMS = 750;
   localparam int CYCLE_LIMIT  = 200000;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_ready;
   logic [5:0]       req_top_count = 0;
   logic [5:0]       req_choose_count = 0;
   logic             rsp_valid;
   logic             rsp_ready = 0;
   logic [VAL_W-1:0] rsp_coefficient;
   int               fail_count, pending_count, answer_count;
   int               cycle_count = 0;
   int               sent_count = 0;
   bit               long_stall = 0;
   bit               stall_done = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   binomial_coefficient_mod_prime_unit DUT (.*);

   bcmp_checker checker_inst (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Valid stays high from one word to the next when there is no gap.
   task automatic send_query(logic [5:0] n, logic [5:0] r);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_top_count <= n;
      req_choose_count <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   // Receiver: random stalls per word, plus one long hold-off once traffic runs.
   initial begin
      int wait_cycles;
      wait (!reset);
      forever begin
         if (long_stall) begin
            rsp_ready <= 0;
            repeat (300) @(posedge clock);
            long_stall = 0;
            stall_done = 1;
         end
         wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
         if (sent_count > 600) wait_cycles = 0;
         if (wait_cycles > 0) begin
            rsp_ready <= 0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      logic [5:0] n, r;
      repeat (11) @(posedge clock);
      reset <= 0;
      // Directed: extremes, r above n, r equal to n, r zero.
      send_query(0, 0);
      send_query(63, 0);
      send_query(63, 63);
      send_query(63, 31);
      send_query(63, 32);
      send_query(0, 63);
      send_query(1, 2);
      send_query(62, 63);
      send_query(1, 1);
      send_query(40, 20);
      send_query(6'h2A, 6'h15);
      send_query(6'h15, 6'h2A);
      send_query(33, 1);
      send_query(33, 32);
      long_stall = 1;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 400) begin
            // Drain completely before continuing.
            req_valid <= 0;
            wait (pending_count == 0);
            @(posedge clock);
         end
         n = 6'($urandom_range(0, 63));
         case ($urandom_range(0, 7))
            0: r = 6'($urandom_range(0, 63));
            1: r = n;
            2: r = 0;
            default: r = 6'($urandom_range(0, n));
         endcase
         send_query(n, r);
      end
      req_valid <= 0;
      wait (pending_count == 0 && stall_done);
      repeat (30) @(posedge clock);
      $display("Sent %0d queries (extremes, r > n, random n and r), checked %0d answers.",
               sent_count, answer_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
